/* design/kf2_pkg.sv */
// kf2_pkg: shared types, constants and saturating fixed-point helpers
// for the two-state kalman step; no dependencies
package kf2_pkg;

    localparam int DataWidth = 32;
    localparam int FracBits  = 16;

    typedef logic signed [DataWidth-1:0] word_t;

    localparam logic [2:0] RegA11 = 3'd0;
    localparam logic [2:0] RegA12 = 3'd1;
    localparam logic [2:0] RegA21 = 3'd2;
    localparam logic [2:0] RegA22 = 3'd3;
    localparam logic [2:0] RegB1  = 3'd4;
    localparam logic [2:0] RegB2  = 3'd5;
    localparam logic [2:0] RegQn  = 3'd6;
    localparam logic [2:0] RegRn  = 3'd7;

    localparam word_t WordMax = {1'b0, {(DataWidth-1){1'b1}}};
    localparam word_t WordMin = {1'b1, {(DataWidth-1){1'b0}}};

    // saturating add/sub of two words
    function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
        logic signed [DataWidth:0] s;
        begin
            s = sub ? ({a[DataWidth-1], a} - {b[DataWidth-1], b})
                    : ({a[DataWidth-1], a} + {b[DataWidth-1], b});
            if (s[DataWidth] != s[DataWidth-1])
                sat_add = s[DataWidth] ? WordMin : WordMax;
            else
                sat_add = s[DataWidth-1:0];
        end
    endfunction

    // magnitude/sign product to rounded, saturated word
    function automatic word_t sat_round(input logic neg, input logic [2*DataWidth-1:0] p);
        logic [2*DataWidth:0]   r;
        logic [2*DataWidth:0]   q;
        logic [DataWidth:0]     lim;
        logic [DataWidth:0]     v;
        begin
            r   = {1'b0, p} + ((2*DataWidth+1)'(1) << (FracBits-1));
            q   = r >> FracBits;
            lim = {2'b00, {(DataWidth-1){1'b1}}} + (DataWidth+1)'(neg);
            if (q > {{(DataWidth){1'b0}}, lim})
                v = lim;
            else
                v = q[DataWidth:0];
            sat_round = neg ? word_t'(-v) : word_t'(v);
        end
    endfunction

    // saturate a magnitude of 2W bits with sign
    function automatic word_t sat_mag(input logic neg, input logic [2*DataWidth-1:0] m);
        logic [DataWidth:0] lim;
        logic [DataWidth:0] v;
        begin
            lim = {2'b00, {(DataWidth-1){1'b1}}} + (DataWidth+1)'(neg);
            if (m > {{(DataWidth-1){1'b0}}, lim})
                v = lim;
            else
                v = m[DataWidth:0];
            sat_mag = neg ? word_t'(-v) : word_t'(v);
        end
    endfunction

endpackage

/* design/kf2_mul.sv */
// kf2_mul: shared multiplier (registered operands and product), pipelined
// depends on kf2_pkg
module kf2_mul
    import kf2_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t p
);
    logic [DataWidth-1:0]   ma_reg, mb_reg;
    logic                   neg_reg;
    logic                   busy_reg;
    logic                   done_reg;
    word_t                  p_reg;
    logic [2*DataWidth-1:0] prod;

    assign prod = {{DataWidth{1'b0}}, ma_reg} * {{DataWidth{1'b0}}, mb_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[DataWidth-1] ? -a : a;
            mb_reg  <= b[DataWidth-1] ? -b : b;
            neg_reg <= a[DataWidth-1] ^ b[DataWidth-1];
        end
        if (busy_reg)
            p_reg <= sat_round(neg_reg, prod);
    end

    assign done = done_reg;
    assign p    = p_reg;
endmodule

/* design/kf2_div.sv */
// kf2_div: restoring divider, (num << frac) / den, one quotient bit per cycle
// depends on kf2_pkg
module kf2_div
    import kf2_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t num,
    input  word_t den,
    output logic  done,
    output word_t q
);
    localparam int NBits = DataWidth + FracBits;
    localparam int CntW  = $clog2(NBits + 1);

    logic [NBits-1:0]   dvd_reg;
    logic [DataWidth:0] rem_reg;
    logic [NBits-1:0]   quo_reg;
    logic [DataWidth-1:0] den_reg;
    logic               neg_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DataWidth:0] trial;
    logic [DataWidth:0] shifted;
    logic [DataWidth-1:0] mag;

    assign mag     = num[DataWidth-1] ? -num : num;
    assign shifted = {rem_reg[DataWidth-1:0], dvd_reg[NBits-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NBits);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {mag, {FracBits{1'b0}}};
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= den;
            neg_reg <= num[DataWidth-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (!trial[DataWidth])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NBits-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[NBits-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign q    = sat_mag(neg_reg, (2*DataWidth)'(quo_reg));
endmodule

/* design/kalman_filter_2state_step.sv */
// kalman_filter_2state_step: top level, register file, sequencer and state
// depends on kf2_pkg, kf2_mul, kf2_div
//
// channel | dir | handshake        | payload
// s_axis  | in  | tvalid/tready    | tdata: control_input[31:0], measurement[63:32]
// m_axis  | out | tvalid/tready    | tdata: state_est_1, state_est_2; tuser: divide_fault
// cfg     | in  | cfg_valid/ready  | cfg_index[2:0], cfg_data[31:0]
//
// one request runs 28 products on the shared multiplier, four adds and two divisions
// before m_axis_tvalid rises; a new request is taken only once the result is accepted.
// when s is not positive the divisions are skipped.
// reset clears the estimate and covariance and loads the matrix defaults.
// s_axis_tready is low while a step runs or a result waits on m_axis.
module kalman_filter_2state_step
    import kf2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // control_input, measurement
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // state_est_1, state_est_2
    output logic        m_axis_tuser,   // divide_fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_ACC  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    // register file of temporaries
    localparam int NR = 24;
    typedef enum logic [4:0] {
        R_U, R_Y, R_XP1, R_XP2, R_M11, R_M12, R_M21, R_M22,
        R_PP11, R_PP12, R_PP22, R_E, R_S, R_K1, R_K2, R_T0, R_T1, R_KK,
        R_X1, R_X2, R_P11, R_P12, R_P22, R_ZERO
    } rid_t;

    // operation: dst = (mac ? t0 + : ) a*b ; kinds for special ops
    typedef enum logic [2:0] {
        OP_MUL, OP_MAC, OP_ADDQ, OP_SUB, OP_DIV, OP_ADDR, OP_MSUB, OP_MADD
    } op_t;

    typedef struct packed {
        op_t  op;
        rid_t dst;
        rid_t sa;
        rid_t sb;
    } instr_t;

    localparam int NI = 40;
    localparam int PcW = $clog2(NI);

    word_t a11_reg, a12_reg, a21_reg, a22_reg, b1_reg, b2_reg, qn_reg, rn_reg;
    word_t rf_reg [NR];
    state_t st_reg;
    logic [PcW-1:0] pc_reg;
    logic fault_reg;
    word_t ma, mb, dn, dd;
    logic mstart, mdone, dstart, ddone;
    word_t mp, dq;
    instr_t ins;
    word_t opa, opb;

    // straight-line program encoded as a table
    always_comb
    begin
        unique case (pc_reg)
            6'd0:  ins = '{OP_MUL,  R_T0,   R_X1,  R_U};    // a11*x1 (coef via code)
            6'd1:  ins = '{OP_MAC,  R_T0,   R_X2,  R_U};
            6'd2:  ins = '{OP_MAC,  R_XP1,  R_U,   R_T0};   // + b1*u
            6'd3:  ins = '{OP_MUL,  R_T0,   R_X1,  R_U};
            6'd4:  ins = '{OP_MAC,  R_T0,   R_X2,  R_U};
            6'd5:  ins = '{OP_MAC,  R_XP2,  R_U,   R_T0};
            6'd6:  ins = '{OP_MUL,  R_T0,   R_P11, R_U};
            6'd7:  ins = '{OP_MAC,  R_M11,  R_P12, R_T0};
            6'd8:  ins = '{OP_MUL,  R_T0,   R_P12, R_U};
            6'd9:  ins = '{OP_MAC,  R_M12,  R_P22, R_T0};
            6'd10: ins = '{OP_MUL,  R_T0,   R_P11, R_U};
            6'd11: ins = '{OP_MAC,  R_M21,  R_P12, R_T0};
            6'd12: ins = '{OP_MUL,  R_T0,   R_P12, R_U};
            6'd13: ins = '{OP_MAC,  R_M22,  R_P22, R_T0};
            6'd14: ins = '{OP_MUL,  R_T0,   R_M11, R_U};
            6'd15: ins = '{OP_MAC,  R_T1,   R_M12, R_T0};
            6'd16: ins = '{OP_ADDQ, R_PP11, R_T1,  R_T1};
            6'd17: ins = '{OP_MUL,  R_T0,   R_M11, R_U};
            6'd18: ins = '{OP_MAC,  R_PP12, R_M12, R_T0};
            6'd19: ins = '{OP_MUL,  R_T0,   R_M21, R_U};
            6'd20: ins = '{OP_MAC,  R_T1,   R_M22, R_T0};
            6'd21: ins = '{OP_ADDQ, R_PP22, R_T1,  R_T1};
            6'd22: ins = '{OP_SUB,  R_E,    R_Y,   R_XP1};
            6'd23: ins = '{OP_ADDR, R_S,    R_PP11, R_PP11};
            6'd24: ins = '{OP_DIV,  R_K1,   R_PP11, R_S};
            6'd25: ins = '{OP_DIV,  R_K2,   R_PP12, R_S};
            6'd26: ins = '{OP_MADD, R_X1,   R_K1,  R_E};    // x1 = xp1 + k1*e
            6'd27: ins = '{OP_MADD, R_X2,   R_K2,  R_E};
            6'd28: ins = '{OP_MUL,  R_KK,   R_K1,  R_K1};
            6'd29: ins = '{OP_MSUB, R_P11,  R_KK,  R_S};
            6'd30: ins = '{OP_MUL,  R_KK,   R_K1,  R_K2};
            6'd31: ins = '{OP_MSUB, R_P12,  R_KK,  R_S};
            6'd32: ins = '{OP_MUL,  R_KK,   R_K2,  R_K2};
            default: ins = '{OP_MSUB, R_P22, R_KK, R_S};
        endcase
    end

    localparam logic [PcW-1:0] PcLast = PcW'(33);

    // multiplier operands with their coefficient, by step
    always_comb
    begin
        opa = rf_reg[ins.sa];
        opb = rf_reg[ins.sb];
        unique case (pc_reg)
            6'd0, 6'd6, 6'd8:   begin opa = a11_reg; opb = rf_reg[ins.sa]; end
            6'd1, 6'd7, 6'd9:   begin opa = a12_reg; opb = rf_reg[ins.sa]; end
            6'd2:               begin opa = b1_reg;  opb = rf_reg[R_U]; end
            6'd3, 6'd10, 6'd12: begin opa = a21_reg; opb = rf_reg[ins.sa]; end
            6'd4, 6'd11, 6'd13: begin opa = a22_reg; opb = rf_reg[ins.sa]; end
            6'd5:               begin opa = b2_reg;  opb = rf_reg[R_U]; end
            6'd14:              begin opa = rf_reg[R_M11]; opb = a11_reg; end
            6'd15:              begin opa = rf_reg[R_M12]; opb = a12_reg; end
            6'd17:              begin opa = rf_reg[R_M11]; opb = a21_reg; end
            6'd18:              begin opa = rf_reg[R_M12]; opb = a22_reg; end
            6'd19:              begin opa = rf_reg[R_M21]; opb = a21_reg; end
            6'd20:              begin opa = rf_reg[R_M22]; opb = a22_reg; end
            default:            ;
        endcase
    end

    // accumulate partner for mac: the result of the previous step (t0)
    word_t macc;
    word_t madd_base;
    always_comb
    begin
        macc = rf_reg[R_T0];
        madd_base = (ins.dst == R_X1) ? rf_reg[R_XP1] :
                    (ins.dst == R_X2) ? rf_reg[R_XP2] : rf_reg[ins.dst];
    end

    logic zero_gain;
    assign zero_gain = fault_reg;

    assign ma = (ins.op == OP_MADD && zero_gain) ? '0 : opa;
    assign mb = opb;
    assign dn = rf_reg[ins.sa];
    assign dd = rf_reg[ins.sb];

    kf2_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a     (ma),
        .b     (mb),
        .done  (mdone),
        .p     (mp)
    );

    kf2_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dn),
        .den   (dd),
        .done  (ddone),
        .q     (dq)
    );

    logic is_mul_op, is_div_op;
    assign is_mul_op = ins.op == OP_MUL || ins.op == OP_MAC || ins.op == OP_MSUB
                    || ins.op == OP_MADD;
    assign is_div_op = ins.op == OP_DIV;
    assign mstart = st_reg == S_ACC && is_mul_op;
    assign dstart = st_reg == S_ACC && is_div_op && !fault_reg;

    assign s_axis_tready = st_reg == S_IDLE;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = st_reg == S_OUT;
    assign m_axis_tdata  = {rf_reg[R_X2], rf_reg[R_X1]};
    assign m_axis_tuser  = fault_reg;

    word_t res;
    always_comb
    begin
        unique case (ins.op)
            OP_MUL:  res = mp;
            OP_MAC:  res = sat_add(macc, mp, 1'b0);
            OP_MADD: res = sat_add(madd_base, mp, 1'b0);
            OP_MSUB: res = sat_add(rf_reg[(ins.dst == R_P11) ? R_PP11 :
                                          (ins.dst == R_P12) ? R_PP12 : R_PP22],
                                   mp, 1'b1);
            OP_DIV:  res = fault_reg ? '0 : dq;
            OP_ADDQ: res = sat_add(rf_reg[ins.sa], qn_reg, 1'b0);
            OP_ADDR: res = sat_add(rf_reg[ins.sa], rn_reg, 1'b0);
            default: res = sat_add(rf_reg[ins.sa], rf_reg[ins.sb], 1'b1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a11_reg <= 32'sd201;
            a12_reg <= -32'sd1570;
            a21_reg <= 32'sd1;
            a22_reg <= 32'sd65536;
            b1_reg  <= 32'sd18665;
            b2_reg  <= 32'sd2;
            qn_reg  <= '0;
            rn_reg  <= '0;
            st_reg  <= S_IDLE;
            pc_reg  <= '0;
            fault_reg <= 1'b0;
            for (int i = 0; i < NR; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    RegA11: a11_reg <= cfg_data;
                    RegA12: a12_reg <= cfg_data;
                    RegA21: a21_reg <= cfg_data;
                    RegA22: a22_reg <= cfg_data;
                    RegB1:  b1_reg  <= cfg_data;
                    RegB2:  b2_reg  <= cfg_data;
                    RegQn:  qn_reg  <= {1'b0, cfg_data[30:0]};
                    default: rn_reg <= {1'b0, cfg_data[30:0]};
                endcase
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        rf_reg[R_U] <= s_axis_tdata[31:0];
                        rf_reg[R_Y] <= s_axis_tdata[63:32];
                        pc_reg <= '0;
                        st_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    if (is_mul_op)
                        st_reg <= S_MUL;
                    else if (is_div_op && !fault_reg)
                        st_reg <= S_DIV;
                    else
                    begin
                        if (ins.op == OP_ADDR)
                            fault_reg <= res[DataWidth-1] || res == '0;
                        rf_reg[ins.dst] <= res;
                        if (pc_reg == PcLast)
                            st_reg <= S_OUT;
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    if (mdone)
                    begin
                        rf_reg[ins.dst] <= res;
                        pc_reg <= pc_reg + 1'b1;
                        st_reg <= (pc_reg == PcLast) ? S_OUT : S_ACC;
                    end
                end
                S_DIV:
                begin
                    if (ddone)
                    begin
                        rf_reg[ins.dst] <= res;
                        pc_reg <= pc_reg + 1'b1;
                        st_reg <= S_ACC;
                    end
                end
                default:
                begin
                    if (m_axis_tready)
                    begin
                        st_reg <= S_IDLE;
                        fault_reg <= 1'b0;
                    end
                end
            endcase
        end
    end
endmodule
